### hw/rtl/srp_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the staircase ramp profile block.
// No dependencies.
package srp_pkg;

    localparam int TIME_WIDTH_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int RAMP_W    = 16;
    localparam int HOLD_W    = 16;
    localparam int STORQ_W   = 12;
    localparam int LEVEL_W   = 4;
    localparam int TORQUE_W  = 16;
    localparam int STEP_W    = 5;
    localparam int PHASE_W   = 2;

    // quotient of S*e/ramp is below S, so it fits the torque-step width
    localparam int QUOT_W = STORQ_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TORQ = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL = 2'd3;

    localparam logic [RAMP_W-1:0]  RAMP_TIME_RST = 16'd1000;
    localparam logic [HOLD_W-1:0]  HOLD_TIME_RST = 16'd2000;
    localparam logic [STORQ_W-1:0] STEP_TORQ_RST = 12'd1000;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL_RST = 4'd10;

    localparam logic [PHASE_W-1:0] PH_RAMP = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HOLD = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

    localparam logic [STEP_W-1:0] STEP_MAX = 5'd30;

endpackage

### hw/rtl/staircase_ramp_profile.sv
`timescale 1ns / 1ps
// Staircase ramp torque setpoint generator, one beat in and one beat out per tick.
// Mid-ramp ticks use the divider (states LOAD, DIV, FIN); other ticks go from EVAL
// straight to OUT. A new input beat is taken only in IDLE, after the last result
// is loaded into the output register. The divider gives one quotient bit per
// cycle, 12 bits. A stalled output holds the next item in the output state.
// Async active-low reset: profile at step 0, ramp phase, registers at defaults.
module staircase_ramp_profile
    import srp_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TORQUE_W-1:0]  torque_mnm,
    output logic [PHASE_W-1:0]   phase_code,
    output logic [STEP_W-1:0]    step_number
);

    localparam int CW = (TIME_WIDTH > RAMP_W) ? TIME_WIDTH : RAMP_W;
    localparam int PW = STORQ_W + TIME_WIDTH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [RAMP_W-1:0]     ramp_time_reg;
    logic [HOLD_W-1:0]     hold_time_reg;
    logic [STORQ_W-1:0]    step_torq_reg;
    logic [LEVEL_W-1:0]    top_level_reg;

    logic [2:0]            state_reg, state_next;
    logic                  restart_reg;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [TIME_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                  rise_reg;
    logic [TORQUE_W-1:0]   base_reg;
    logic [PW-1:0]         prod_reg;
    logic [TORQUE_W-1:0]   res_reg, res_next;
    logic                  out_valid_reg;
    logic [TORQUE_W-1:0]   out_torque_reg;
    logic [PHASE_W-1:0]    out_phase_reg;
    logic [STEP_W-1:0]     out_step_reg;

    logic [TIME_WIDTH-1:0] e_inc;
    logic [STEP_W-1:0]     last;
    logic [STEP_W-1:0]     fall_from;
    logic [STEP_W-1:0]     from_lvl;
    logic [STEP_W-1:0]     to_lvl;
    logic [STEP_W-1:0]     lvl_sel;
    logic [TORQUE_W-1:0]   lvl_torque;
    logic                  rising;
    logic                  need_div;
    logic                  load_out;

    logic                  div_start;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_time_reg <= RAMP_TIME_RST;
            hold_time_reg <= HOLD_TIME_RST;
            step_torq_reg <= STEP_TORQ_RST;
            top_level_reg <= TOP_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RAMP_TIME: ramp_time_reg <= cfg_data[RAMP_W-1:0];
                CFG_HOLD_TIME: hold_time_reg <= cfg_data[HOLD_W-1:0];
                CFG_STEP_TORQ: step_torq_reg <= cfg_data[STORQ_W-1:0];
                CFG_TOP_LEVEL: top_level_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // step decode
    assign e_inc = (elapsed_reg == {TIME_WIDTH{1'b1}}) ? elapsed_reg
                                                       : elapsed_reg + TIME_WIDTH'(1);
    assign last       = {top_level_reg, 1'b0};
    assign rising     = (step_reg < {1'b0, top_level_reg});
    assign fall_from  = last - step_reg;
    assign from_lvl   = rising ? step_reg : fall_from;
    assign to_lvl     = rising ? step_reg + STEP_W'(1) : fall_from - STEP_W'(1);
    // mid-ramp tick: interpolate from the starting level
    assign need_div   = !restart_reg && (phase_reg == PH_RAMP) && (step_reg < last)
                        && (CW'(e_inc) < CW'(ramp_time_reg));
    assign lvl_sel    = need_div ? from_lvl : to_lvl;
    assign lvl_torque = TORQUE_W'({{(TORQUE_W-STEP_W){1'b0}}, lvl_sel}
                                  * {{(TORQUE_W-STORQ_W){1'b0}}, step_torq_reg});

    always_comb
    begin
        step_next    = step_reg;
        phase_next   = phase_reg;
        elapsed_next = e_inc;
        res_next     = '0;
        if (restart_reg)
        begin
            step_next    = '0;
            phase_next   = PH_RAMP;
            elapsed_next = '0;
        end
        else if ((phase_reg != PH_RAMP && phase_reg != PH_HOLD) || (step_reg >= last))
        begin
            phase_next = PH_DONE;
        end
        else if (phase_reg == PH_RAMP)
        begin
            if (!need_div)
            begin
                phase_next   = PH_HOLD;
                elapsed_next = '0;
                res_next     = lvl_torque;
            end
        end
        else
        begin
            res_next = lvl_torque;
            if (CW'(e_inc) >= CW'(hold_time_reg))
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg + STEP_W'(1) >= last)
                begin
                    phase_next = PH_DONE;
                    res_next   = '0;
                end
                else
                begin
                    phase_next   = PH_RAMP;
                    elapsed_next = '0;
                end
            end
        end
    end

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EVAL;
            ST_EVAL: state_next = need_div ? ST_LOAD : ST_OUT;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= PH_RAMP;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EVAL)
            begin
                step_reg    <= step_next;
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
            restart_reg <= restart;
        if (state_reg == ST_EVAL)
        begin
            rise_reg <= rising;
            base_reg <= lvl_torque;
            prod_reg <= PW'(step_torq_reg) * PW'(e_inc);
            res_reg  <= res_next;
        end
        else if (state_reg == ST_FIN)
        begin
            // falling ramps never go below zero: d < S
            res_reg <= rise_reg ? base_reg + TORQUE_W'(div_quot)
                                : base_reg - TORQUE_W'(div_quot);
        end
        if (load_out)
        begin
            out_torque_reg <= res_reg;
            out_phase_reg  <= phase_reg;
            out_step_reg   <= step_reg;
        end
    end

    assign div_start = (state_reg == ST_LOAD);

    srp_div #(
        .PW(PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (ramp_time_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign torque_mnm  = out_torque_reg;
    assign phase_code  = out_phase_reg;
    assign step_number = out_step_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase_code == PH_DONE) |-> (torque_mnm == '0))
        else $error("finished profile with nonzero torque");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_MAX)
        else $error("step index past end of profile");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EVAL))
        else $error("accepted beat not evaluated");

endmodule

### hw/rtl/srp_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, quotient known to be below 2**QUOT_W.
// Depends on srp_pkg.
module srp_div
    import srp_pkg::*;
#(
    parameter int PW = STORQ_W + TIME_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PW-1:0]     dividend,
    input  logic [RAMP_W-1:0] divisor,
    output logic              done,
    output logic [QUOT_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAMP_W-1:0] rem_reg, rem_next;
    logic [RAMP_W-1:0] dvs_reg, dvs_next;
    logic [QUOT_W-1:0] shf_reg, shf_next;

    logic [RAMP_W:0]   trial;
    logic              ge;

    // partial remainder stays below the divisor, so one extra bit is enough
    assign trial = {rem_reg, shf_reg[QUOT_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = RAMP_W'(dividend >> QUOT_W);
            shf_next  = dividend[QUOT_W-1:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? RAMP_W'(trial - {1'b0, dvs_reg}) : trial[RAMP_W-1:0];
            shf_next = {shf_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        shf_reg <= shf_next;
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without an iteration");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= CNT_W'(QUOT_W - 1)))
        else $error("divider count out of range");

endmodule
